FILE: sv/tdw_pkg.sv
// ----------------------------------------------------------------------------
// tdw_pkg
// Shared types and constants of the task delay and wake-up tables.
// ----------------------------------------------------------------------------
package tdw_pkg;

    // Number of priorities served by the tables
    localparam int NUM_PRIORITIES = 32;

    // Field widths fixed by the interface
    localparam int PRIO_FIELD_W = 5;
    localparam int TICKS_W      = 16;
    localparam int TICK_W       = 32;
    localparam int MASK_W       = 32;

    // Derived widths
    localparam int PRIO_W   = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
    localparam int TAB_DEPTH = 2 * NUM_PRIORITIES;
    localparam int ADDR_W   = $clog2(TAB_DEPTH);
    localparam int CNT_W    = $clog2(NUM_PRIORITIES + 1);

    // Request kinds
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_DELAY = 1'b1;

    typedef struct packed {
        logic                    req_type;
        logic [PRIO_FIELD_W-1:0] priority_req;
        logic [TICKS_W-1:0]      ticks;
    } tdw_req_t;

    typedef struct packed {
        logic [MASK_W-1:0] woken_mask;
        logic [MASK_W-1:0] slept_mask;
        logic [MASK_W-1:0] delayed_mask;
        logic [TICK_W-1:0] tick_now;
    } tdw_res_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic              load;
        logic              delay_write;
        logic              tick_inc;
        logic [PRIO_W-1:0] rd_idx;
        logic              cmp_en;
        logic [PRIO_W-1:0] cmp_idx;
        logic              finish;
    } tdw_cmd_t;

endpackage

FILE: sv/tdw_ram.sv
// ----------------------------------------------------------------------------
// tdw_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tdw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/tdw_ctrl.sv
// ----------------------------------------------------------------------------
// tdw_ctrl
// Sequencer: decodes a request and steps the wake-table scan on a tick.
// ----------------------------------------------------------------------------
module tdw_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             req_type,
    output logic             busy,
    output tdw_pkg::tdw_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DELAY,
        ST_INC,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t                      state_reg, state_next;
    logic [tdw_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                        cmp_pend_reg, cmp_pend_next;
    logic [tdw_pkg::PRIO_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic                        scan_end;

    assign scan_end = (cnt_reg == tdw_pkg::CNT_W'(tdw_pkg::NUM_PRIORITIES));

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cmp_pend_next = 1'b0;
        cmp_idx_next  = cmp_idx_reg;
        cmd           = '0;
        cmd.rd_idx    = cnt_reg[tdw_pkg::PRIO_W-1:0];
        cmd.cmp_idx   = cmp_idx_reg;
        cmd.cmp_en    = cmp_pend_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (req_type == tdw_pkg::REQ_DELAY)
                    begin
                        state_next = ST_DELAY;
                    end
                    else
                    begin
                        state_next = ST_INC;
                    end
                end
            end
            ST_DELAY:
            begin
                cmd.delay_write = 1'b1;
                state_next      = ST_DONE;
            end
            ST_INC:
            begin
                cmd.tick_inc = 1'b1;
                cnt_next     = '0;
                state_next   = ST_SCAN;
            end
            ST_SCAN:
            begin
                // issue one read a cycle; compare the previous entry
                if (scan_end)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmp_pend_next = 1'b1;
                    cmp_idx_next  = cnt_reg[tdw_pkg::PRIO_W-1:0];
                    cnt_next      = cnt_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and scan position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            cmp_pend_reg <= 1'b0;
            cmp_idx_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            cmp_pend_reg <= cmp_pend_next;
            cmp_idx_reg  <= cmp_idx_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

FILE: sv/tdw_datapath.sv
// ----------------------------------------------------------------------------
// tdw_datapath
// Tick counter, wake-time tables with valid bits, delay bitmap and result.
// ----------------------------------------------------------------------------
module tdw_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  tdw_pkg::tdw_cmd_t cmd,
    input  tdw_pkg::tdw_req_t request,
    output logic              result_valid,
    output tdw_pkg::tdw_res_t result
);

    tdw_pkg::tdw_req_t             req_reg;
    logic [tdw_pkg::TICK_W-1:0]    tick_reg;
    logic                          cur_reg;
    logic [tdw_pkg::MASK_W-1:0]    delay_reg;
    logic [tdw_pkg::MASK_W-1:0]    woken_reg;
    logic [tdw_pkg::MASK_W-1:0]    slept_reg;
    logic [tdw_pkg::TAB_DEPTH-1:0] valid_reg;
    tdw_pkg::tdw_res_t             result_reg;
    logic                          result_valid_reg;

    logic [tdw_pkg::TICK_W:0]      sum;
    logic [tdw_pkg::TICK_W-1:0]    wake;
    logic [tdw_pkg::TICK_W-1:0]    tick_inc_val;
    logic                          prio_ok;
    logic [tdw_pkg::PRIO_W-1:0]    prio;
    logic [tdw_pkg::ADDR_W-1:0]    waddr;
    logic [tdw_pkg::ADDR_W-1:0]    raddr;
    logic [tdw_pkg::ADDR_W-1:0]    caddr;
    logic [tdw_pkg::TICK_W-1:0]    rdata;
    logic                          we;
    logic                          hit;
    logic [tdw_pkg::MASK_W-1:0]    delay_fin;

    // Table a occupies the lower half, table b the upper half
    function automatic logic [tdw_pkg::ADDR_W-1:0] tab_addr(
        input logic                       sel,
        input logic [tdw_pkg::PRIO_W-1:0] idx
    );
        logic [tdw_pkg::ADDR_W-1:0] base;
        base = sel ? tdw_pkg::ADDR_W'(tdw_pkg::NUM_PRIORITIES) : '0;
        return base + tdw_pkg::ADDR_W'(idx);
    endfunction

    // Wake time and the table it lands in
    assign sum     = {1'b0, tick_reg} + (tdw_pkg::TICK_W + 1)'(req_reg.ticks);
    assign wake    = sum[tdw_pkg::TICK_W-1:0];
    assign prio_ok = ({1'b0, req_reg.priority_req}
                     < (tdw_pkg::PRIO_FIELD_W + 1)'(tdw_pkg::NUM_PRIORITIES));
    assign prio    = req_reg.priority_req[tdw_pkg::PRIO_W-1:0];
    assign waddr   = tab_addr(cur_reg ^ sum[tdw_pkg::TICK_W], prio);
    assign we      = cmd.delay_write && prio_ok;
    assign raddr   = tab_addr(cur_reg, cmd.rd_idx);
    assign caddr   = tab_addr(cur_reg, cmd.cmp_idx);

    assign tick_inc_val = tick_reg + 1'b1;

    // A live entry at or below the count wakes its priority
    assign hit       = valid_reg[caddr] && (rdata <= tick_reg);
    assign delay_fin = (delay_reg | slept_reg) & ~woken_reg;

    tdw_ram #(
        .WIDTH (tdw_pkg::TICK_W),
        .DEPTH (tdw_pkg::TAB_DEPTH)
    ) u_tab (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wake),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Latch the request payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= request;
        end
    end

    // Update counter, tables, bitmap and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg         <= '0;
            cur_reg          <= 1'b0;
            delay_reg        <= '0;
            woken_reg        <= '0;
            slept_reg        <= '0;
            valid_reg        <= '0;
            result_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            if (cmd.load)
            begin
                woken_reg <= '0;
                slept_reg <= '0;
            end
            if (we)
            begin
                // a zero wake time is stored as not waiting
                valid_reg[waddr] <= (wake != '0);
                slept_reg        <= tdw_pkg::MASK_W'(1) << req_reg.priority_req;
            end
            if (cmd.tick_inc)
            begin
                tick_reg <= tick_inc_val;
                if (tick_inc_val == '0)
                begin
                    cur_reg <= ~cur_reg;
                end
            end
            if (cmd.cmp_en && hit)
            begin
                valid_reg[caddr]      <= 1'b0;
                woken_reg[cmd.cmp_idx] <= 1'b1;
            end
            if (cmd.finish)
            begin
                delay_reg               <= delay_fin;
                result_reg.woken_mask   <= woken_reg;
                result_reg.slept_mask   <= slept_reg;
                result_reg.delayed_mask <= delay_fin;
                result_reg.tick_now     <= tick_reg;
                result_valid_reg        <= 1'b1;
            end
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

FILE: sv/task_delay_wakeup_tables.sv
// ----------------------------------------------------------------------------
// task_delay_wakeup_tables
// Delay list with current and after-wrap wake-time tables and a tick counter.
// ----------------------------------------------------------------------------
//  channel   | handshake              | payload
//  ----------+------------------------+-----------------------------
//  request   | start high, busy low   | request (tdw_req_t)
//  result    | result_valid, 1 cycle  | result  (tdw_res_t)
//
//  A delay request passes the delay-write and done states before its result strobe;
//  a tick passes the increment, scan and done states, and the scan reads one wake
//  table entry per cycle through the single read port of the table RAM.
//  Table entries are cleared at reset through valid bits, so no clearing pass.
//  The result strobe is high for one cycle only; the next request may be accepted in
//  that same cycle.
// ----------------------------------------------------------------------------
module task_delay_wakeup_tables (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tdw_pkg::tdw_req_t request,
    output logic              result_valid,
    output tdw_pkg::tdw_res_t result
);

    tdw_pkg::tdw_cmd_t cmd;

    tdw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (request.req_type),
        .busy     (busy),
        .cmd      (cmd)
    );

    tdw_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .request      (request),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

FILE: verif/tdw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdw_checker
// Watches the request and result channels of the task delay tables, keeps its
// own copy of the tick counter, both wake tables and the delayed bitmap, works
// out the result of each accepted request and compares every result strobe,
// field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tdw_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  tdw_pkg::tdw_req_t request,
    input  logic              result_valid,
    input  tdw_pkg::tdw_res_t result,
    output int                fail_count,
    output int                pending
);

    localparam int REPORT_LIMIT = 10;

    // Shadow state of the block
    logic [tdw_pkg::TICK_W-1:0] tick_cnt;
    logic [tdw_pkg::TICK_W-1:0] wake_a [tdw_pkg::NUM_PRIORITIES];
    logic [tdw_pkg::TICK_W-1:0] wake_b [tdw_pkg::NUM_PRIORITIES];
    logic                       cur_is_b;
    logic [tdw_pkg::MASK_W-1:0] delayed_bits;

    // Predicted results still waiting for their strobe, oldest first
    tdw_pkg::tdw_res_t due_results [$];
    tdw_pkg::tdw_res_t want;

    // Apply one request to the shadow tables and return the result it gives
    function automatic tdw_pkg::tdw_res_t schedule_step(input tdw_pkg::tdw_req_t r);
        tdw_pkg::tdw_res_t          o;
        logic [tdw_pkg::TICK_W:0]   wake_sum;
        logic [tdw_pkg::TICK_W-1:0] entry;
        logic [tdw_pkg::MASK_W-1:0] woken;
        int                         i;
        o     = '0;
        woken = '0;
        if (r.req_type == tdw_pkg::REQ_DELAY)
        begin
            if (int'(r.priority_req) < tdw_pkg::NUM_PRIORITIES)
            begin
                wake_sum = {1'b0, tick_cnt}
                         + {{(tdw_pkg::TICK_W - tdw_pkg::TICKS_W + 1){1'b0}}, r.ticks};
                // a carry out means the wake time falls in the next counter round
                if (wake_sum[tdw_pkg::TICK_W] != cur_is_b)
                    wake_b[r.priority_req] = wake_sum[tdw_pkg::TICK_W-1:0];
                else
                    wake_a[r.priority_req] = wake_sum[tdw_pkg::TICK_W-1:0];
                o.slept_mask = tdw_pkg::MASK_W'(1) << r.priority_req;
                delayed_bits = delayed_bits | o.slept_mask;
            end
        end
        else
        begin
            // advance the counter and swap table roles on wrap to zero
            tick_cnt = tick_cnt + 1'b1;
            if (tick_cnt == '0)
                cur_is_b = !cur_is_b;
            for (i = 0; i < tdw_pkg::NUM_PRIORITIES; i++)
            begin
                entry = cur_is_b ? wake_b[i] : wake_a[i];
                if (entry != '0 && entry <= tick_cnt)
                begin
                    if (cur_is_b)
                        wake_b[i] = '0;
                    else
                        wake_a[i] = '0;
                    woken[i] = 1'b1;
                end
            end
            delayed_bits = delayed_bits & ~woken;
        end
        o.woken_mask   = woken;
        o.delayed_mask = delayed_bits;
        o.tick_now     = tick_cnt;
        return o;
    endfunction

    // Check each result strobe, then log the request accepted at this edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_cnt     = '0;
            cur_is_b     = 1'b0;
            delayed_bits = '0;
            for (int i = 0; i < tdw_pkg::NUM_PRIORITIES; i++)
            begin
                wake_a[i] = '0;
                wake_b[i] = '0;
            end
            due_results.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (due_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: result with no request outstanding: woken %h slept %h",
                                 $realtime, result.woken_mask, result.slept_mask);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (result.woken_mask !== want.woken_mask
                        || result.slept_mask !== want.slept_mask
                        || result.delayed_mask !== want.delayed_mask
                        || result.tick_now !== want.tick_now)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                        begin
                            $display("%0t: result mismatch", $realtime);
                            $display("  expected woken %h slept %h delayed %h tick %h",
                                     want.woken_mask, want.slept_mask,
                                     want.delayed_mask, want.tick_now);
                            $display("  actual   woken %h slept %h delayed %h tick %h",
                                     result.woken_mask, result.slept_mask,
                                     result.delayed_mask, result.tick_now);
                        end
                    end
                end
            end
            if (start && !busy)
                due_results.push_back(schedule_step(request));
            pending = due_results.size();
        end
    end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Top of the task delay tables bench: drives directed and random tick and
// delay requests with random idle bursts, and gives the verdict from the
// failure count of the checker that sits beside the block.
// ----------------------------------------------------------------------------
module tb;

    localparam int RANDOM_REQS  = 1500;
    localparam int QUIET_TAIL   = 200;
    localparam int DRAIN_CYCLES = 40;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    tdw_pkg::tdw_req_t request;
    logic              result_valid;
    tdw_pkg::tdw_res_t result;
    int                fail_count;
    int                pending;

    task_delay_wakeup_tables dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result)
    );

    tdw_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // 4 ns clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Stop a hung run
    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic tdw_pkg::tdw_req_t delay_req(input int prio, input int len);
        tdw_pkg::tdw_req_t r;
        r.req_type     = tdw_pkg::REQ_DELAY;
        r.priority_req = tdw_pkg::PRIO_FIELD_W'(prio);
        r.ticks        = tdw_pkg::TICKS_W'(len);
        return r;
    endfunction

    // Tick with noise in the fields it ignores
    function automatic tdw_pkg::tdw_req_t tick_req();
        tdw_pkg::tdw_req_t r;
        r.req_type     = tdw_pkg::REQ_TICK;
        r.priority_req = tdw_pkg::PRIO_FIELD_W'($urandom_range(0, 31));
        r.ticks        = tdw_pkg::TICKS_W'($urandom_range(0, 65535));
        return r;
    endfunction

    // Hold the request until accepted, then maybe drop start for a short burst
    task automatic send(input tdw_pkg::tdw_req_t r, input bit may_idle);
        start   <= 1'b1;
        request <= r;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        if (may_idle && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    initial
    begin
        tdw_pkg::tdw_req_t r;
        int                pick;

        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // wake time of zero: stored as not waiting, priority stays delayed
        send(delay_req(0, 0), 1'b1);
        send(tick_req(), 1'b1);
        // zero ticks: expires on the next tick
        send(delay_req(31, 0), 1'b1);
        send(tick_req(), 1'b1);
        // longest sleep, then overwritten by a short one
        send(delay_req(5, 65535), 1'b1);
        send(delay_req(5, 2), 1'b1);
        send(tick_req(), 1'b1);
        send(tick_req(), 1'b1);
        send(tick_req(), 1'b1);
        // a fresh entry releases the priority stuck since the first request
        send(delay_req(0, 1), 1'b1);
        send(tick_req(), 1'b1);
        // several priorities woken by the same tick
        send(delay_req(1, 3), 1'b1);
        send(delay_req(2, 3), 1'b1);
        send(delay_req(30, 3), 1'b1);
        send(delay_req(16, 16'h5555), 1'b1);
        send(delay_req(17, 16'hAAAA), 1'b1);
        repeat (4) send(tick_req(), 1'b1);
        send(delay_req(8, 1), 1'b0);
        send(tick_req(), 1'b0);

        // random mix: mostly short sleeps so that wake-ups keep happening
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            if ($urandom_range(0, 99) < 55)
            begin
                r = tick_req();
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    r = delay_req($urandom_range(0, 31), $urandom_range(0, 24));
                else if (pick < 85)
                    r = delay_req($urandom_range(0, 31), $urandom_range(0, 300));
                else
                    r = delay_req($urandom_range(0, 31), $urandom_range(0, 65535));
            end
            send(r, n < RANDOM_REQS - QUIET_TAIL);
        end

        // drain outstanding results, then allow for a stray late strobe
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
